// ===== rtl/core/kle_pkg.sv =====
// package with shared types and constants of the keyboard line editor
`timescale 1ns / 1ps

package kle_pkg;

	localparam int MAX_CAPACITY = 255;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] KEY_NUL = 8'h00;
	localparam logic [7:0] KEY_BS  = 8'h08;
	localparam logic [7:0] KEY_LF  = 8'h0A;
	localparam logic [7:0] KEY_CR  = 8'h0D;
	localparam logic [7:0] KEY_SP  = 8'h20;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_KEY   = 1'b1;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_ECHO  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	typedef enum logic [1:0] {
		OP_DONE0,
		OP_ERASE,
		OP_EOL,
		OP_CHAR
	} op_t;

	typedef logic [1:0] step_t;

	typedef struct packed {
		op_t        op;
		logic       fin;
		logic [7:0] pos;
		logic [7:0] key;
	} cmd_t;

endpackage

// ===== rtl/core/kle_front.sv =====
// front end: input and config intake, line state and command classification
`timescale 1ns / 1ps

module kle_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data,
	output logic         push,
	output kle_pkg::cmd_t push_cmd,
	input  logic         full
);
	import kle_pkg::*;

	logic [7:0] cfg_q;
	logic       armed_q;
	logic [7:0] count_q;
	logic [7:0] cap_q;

	logic       take;
	logic [7:0] cap_eff;
	logic [8:0] cnt_inc;
	logic       fin;
	logic       armed_d;
	logic [7:0] count_d;
	logic [7:0] cap_d;

	assign s_axis_tready = !full;
	assign cfg_ready     = 1'b1;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign cap_eff = (9'(cfg_q) > 9'(MAX_CAPACITY)) ? 8'(MAX_CAPACITY) : cfg_q;
	assign cnt_inc = {1'b0, count_q} + 9'd1;
	assign fin     = cnt_inc >= {1'b0, cap_q};

	always_comb begin
		armed_d      = armed_q;
		count_d      = count_q;
		cap_d        = cap_q;
		push         = 1'b0;
		push_cmd.op  = OP_CHAR;
		push_cmd.fin = fin;
		push_cmd.pos = count_q;
		push_cmd.key = s_axis_tdata;
		if (take) begin
			if (s_axis_tuser == ACT_START) begin
				count_d = '0;
				if (cap_eff == 8'd0) begin
					armed_d     = 1'b0;
					cap_d       = '0;
					push        = 1'b1;
					push_cmd.op = OP_DONE0;
				end else begin
					armed_d = 1'b1;
					cap_d   = cap_eff;
				end
			end else if (armed_q && s_axis_tdata != KEY_NUL) begin
				if (s_axis_tdata == KEY_BS) begin
					if (count_q != 8'd0) begin
						count_d     = count_q - 8'd1;
						push        = 1'b1;
						push_cmd.op = OP_ERASE;
					end
				end else if (s_axis_tdata == KEY_CR || s_axis_tdata == KEY_LF) begin
					armed_d     = 1'b0;
					push        = 1'b1;
					push_cmd.op = OP_EOL;
				end else begin
					count_d     = cnt_inc[7:0];
					push        = 1'b1;
					push_cmd.op = OP_CHAR;
					if (fin) begin
						armed_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= 8'd255;
			armed_q <= 1'b0;
			count_q <= '0;
			cap_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			armed_q <= armed_d;
			count_q <= count_d;
			cap_q   <= cap_d;
		end
	end

endmodule

// ===== rtl/core/kle_queue.sv =====
// short command queue between front end and back end
`timescale 1ns / 1ps

module kle_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kle_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output kle_pkg::cmd_t pop_cmd,
	output logic          empty
);
	import kle_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   fill_q;

	assign full    = fill_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty   = fill_q == '0;
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			fill_q <= fill_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

// ===== rtl/core/kle_back.sv =====
// back end: expands each command into result transfers through an output register
`timescale 1ns / 1ps

module kle_back (
	input  logic          clk,
	input  logic          arst_n,
	input  kle_pkg::cmd_t pop_cmd,
	input  logic          empty,
	output logic          pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [23:0]   m_axis_tdata,
	output logic [1:0]    m_axis_tuser,
	output logic          m_axis_tlast
);
	import kle_pkg::*;

	cmd_t       cur_q;
	logic       cur_valid_q;
	step_t      step_q;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] pos_q;
	logic [7:0] val_q;
	logic [7:0] len_q;
	logic       last_q;

	logic       out_free;
	logic       emit;
	logic [1:0] r_kind;
	logic [7:0] r_pos;
	logic [7:0] r_val;
	logic [7:0] r_len;
	logic       r_last;

	assign out_free = !out_valid_q || m_axis_tready;
	assign emit     = cur_valid_q && out_free;
	assign pop      = !empty && (!cur_valid_q || (emit && r_last));

	always_comb begin
		r_kind = KIND_ECHO;
		r_pos  = '0;
		r_val  = '0;
		r_len  = '0;
		r_last = 1'b0;
		unique case (cur_q.op)
			OP_DONE0: begin
				r_kind = KIND_DONE;
				r_last = 1'b1;
			end
			OP_ERASE: begin
				r_val  = (step_q == 2'd1) ? KEY_SP : KEY_BS;
				r_last = step_q == 2'd2;
			end
			OP_EOL: begin
				unique case (step_q)
					2'd0: begin
						r_kind = KIND_WRITE;
						r_pos  = cur_q.pos;
					end
					2'd1: r_val = KEY_CR;
					2'd2: r_val = KEY_LF;
					default: begin
						r_kind = KIND_DONE;
						r_len  = cur_q.pos;
						r_last = 1'b1;
					end
				endcase
			end
			default: begin
				unique case (step_q)
					2'd0: begin
						r_kind = KIND_WRITE;
						r_pos  = cur_q.pos;
						r_val  = cur_q.key;
					end
					2'd1: begin
						r_val  = cur_q.key;
						r_last = !cur_q.fin;
					end
					default: begin
						r_kind = KIND_DONE;
						r_len  = cur_q.pos + 8'd1;
						r_last = 1'b1;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_cmd;
		end
		if (emit) begin
			kind_q <= r_kind;
			pos_q  <= r_pos;
			val_q  <= r_val;
			len_q  <= r_len;
			last_q <= r_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (emit) begin
				if (r_last) begin
					cur_valid_q <= 1'b0;
				end
				step_q <= step_q + 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {len_q, val_q, pos_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

endmodule

// ===== rtl/core/keyboard_line_editor.sv =====
// keyboard line editor: input stream of start and key items, output stream of results
// Usage:
//   slave stream: tuser is the action (start a line or key byte), tdata the key code.
//   master stream: tuser is the kind (buffer write, echo, line done), tdata holds
//   position, byte value and line length, tlast marks the final result of an input.
//   cfg channel writes the line capacity; write it only while the block is idle.
// Results and throughput:
//   a key that causes results goes through the command queue, the back end's command
//   register and the output register. Each input yields 0 to 4 results (a typed
//   character 2 or 3, an erase 3, an end of line 4); the back end sends one result
//   per cycle while the receiver takes them. Inputs are taken every cycle while the
//   4-entry command queue has room; inputs with no results never enter the queue.
// Reset:
//   the editor is idle with a zero count, capacity register is 255, queue and output
//   register are empty.
// Stalls:
//   when the receiver holds tready low the output register keeps its result, the back
//   end waits and the queue fills; s_axis_tready falls only when the queue is full.
`timescale 1ns / 1ps

module keyboard_line_editor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // key_char
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // position, byte_value, line_length
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import kle_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	cmd_t pop_cmd;
	logic empty;

	kle_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.push         (push),
		.push_cmd     (push_cmd),
		.full         (full)
	);

	kle_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.empty   (empty)
	);

	kle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_cmd      (pop_cmd),
		.empty        (empty),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

// ===== rtl/core/kle_checker.sv =====
// port checker for the keyboard line editor and its bind
`timescale 1ns / 1ps

module kle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import kle_pkg::*;

	// stalled result transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// line done always closes the results of its input
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tlast)
		else $error("done result without tlast");

	// a buffer write is always followed by more results of the same input
	a_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_WRITE |-> !m_axis_tlast
		&& m_axis_tdata[23:16] == 8'd0)
		else $error("write result marked last or with length");

	// echo results carry only a byte
	a_echo_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ECHO |-> m_axis_tdata[7:0] == 8'd0
		&& m_axis_tdata[23:16] == 8'd0)
		else $error("echo result with position or length");

endmodule

bind keyboard_line_editor kle_checker u_kle_checker (.*);
